// ----- hw/rtl/ps2ws_pkg.sv -----
// shared types, constants and register indexes for the ps2 wheel scroll core
// no dependencies; compiled first
package ps2ws_pkg;

   localparam int ROW_BITS_DEF = 12;

   localparam int BYTE_W  = 8;
   localparam int TIME_W  = 64;
   localparam int FIELD_W = 12;
   localparam int MULT_W  = 4;
   localparam int CSR_IDX_W = 2;

   localparam int SYNC_BIT = 3;
   localparam int SIGN_BIT = 7;

   localparam logic [TIME_W-1:0]  FAST_THRESHOLD_RST  = 64'd10000000;
   localparam logic [MULT_W-1:0]  FAST_MULTIPLIER_RST = 4'd3;
   localparam logic [FIELD_W-1:0] SCREEN_ROWS_RST     = 12'd25;
   localparam logic [MULT_W-1:0]  SLOW_STEP           = 4'd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FAST_THRESHOLD  = 2'd0,
      CSR_FAST_MULTIPLIER = 2'd1,
      CSR_SCREEN_ROWS     = 2'd2
   } csr_index_type;

   // packet framer position, one-hot
   typedef enum logic [3:0] {
      POS_SYNC  = 4'b0001,
      POS_X     = 4'b0010,
      POS_Y     = 4'b0100,
      POS_WHEEL = 4'b1000
   } pos_type;

   typedef struct packed {
      logic [TIME_W-1:0]  fast_threshold;
      logic [MULT_W-1:0]  fast_multiplier;
      logic [FIELD_W-1:0] screen_rows;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  data_byte;
      logic [TIME_W-1:0]  time_stamp;
      logic [FIELD_W-1:0] content_rows;
   } item_type;

   typedef struct packed {
      logic [FIELD_W-1:0] view_row;
      logic               refresh;
      logic               packet_done;
      logic               sync_drop;
   } result_type;

endpackage

// ----- hw/rtl/ps2ws_if.sv -----
// valid/ready channel interfaces for the byte input and the result output
// depends on ps2ws_pkg
interface ps2ws_req_if;
   import ps2ws_pkg::*;
   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  data_byte;
   logic [TIME_W-1:0]  time_stamp;
   logic [FIELD_W-1:0] content_rows;

   modport source (output valid, output data_byte, output time_stamp,
                   output content_rows, input ready);
   modport sink (input valid, input data_byte, input time_stamp,
                 input content_rows, output ready);
endinterface

interface ps2ws_rsp_if;
   import ps2ws_pkg::*;
   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] view_row;
   logic               refresh;
   logic               packet_done;
   logic               sync_drop;

   modport source (output valid, output view_row, output refresh,
                   output packet_done, output sync_drop, input ready);
   modport sink (input valid, input view_row, input refresh,
                 input packet_done, input sync_drop, output ready);
endinterface

// ----- hw/rtl/ps2_wheel_packet_scroll_core.sv -----
// ps2 wheel-mouse packet framer with accelerated wheel scrolling of a text view
// depends on ps2ws_pkg, ps2ws_if and ps2ws_step
//
// Takes one mouse byte per cycle on req_chan and gives one result word per byte on
// rsp_chan, in order. A byte is captured in an input register, the framing and
// scroll update run combinationally from that register into the result register,
// so a steady stream moves at one byte per clock; a stalled result holds the result
// register and one more byte waits in the input register before req_chan.ready
// drops. Framing, the wheel step and the row clamp all live in the one compute
// stage, whose longest path is the 64-bit time gap subtract and threshold compare.
// The user must write registers through csr_we/csr_index/csr_wdata only while no
// byte is in flight; the core itself does not enforce this.
module ps2_wheel_packet_scroll_core #(
   parameter int ROW_BITS = ps2ws_pkg::ROW_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   ps2ws_req_if.sink                         req_chan,
   ps2ws_rsp_if.source                       rsp_chan,
   input  logic                              csr_we,
   input  logic [ps2ws_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ps2ws_pkg::TIME_W-1:0]      csr_wdata
);
   import ps2ws_pkg::*;

   cfg_type              cfg_ff;
   logic                 s1_valid_ff;
   item_type             s1_item_ff;
   logic                 rsp_valid_ff;
   result_type           rsp_ff;
   pos_type              pos_ff, pos_in;
   logic [TIME_W-1:0]    scroll_time_ff, scroll_time_in;
   logic [ROW_BITS-1:0]  view_ff, view_in;
   result_type           result_in;
   logic                 s1_fire, req_fire;

   assign s1_fire  = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_fire;
   assign req_fire = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fast_threshold  <= FAST_THRESHOLD_RST;
         cfg_ff.fast_multiplier <= FAST_MULTIPLIER_RST;
         cfg_ff.screen_rows     <= SCREEN_ROWS_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_FAST_THRESHOLD:  cfg_ff.fast_threshold  <= csr_wdata;
            CSR_FAST_MULTIPLIER: cfg_ff.fast_multiplier <= csr_wdata[MULT_W-1:0];
            CSR_SCREEN_ROWS:     cfg_ff.screen_rows     <= csr_wdata[FIELD_W-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
      if (req_fire) begin
         s1_item_ff.data_byte    <= req_chan.data_byte;
         s1_item_ff.time_stamp   <= req_chan.time_stamp;
         s1_item_ff.content_rows <= req_chan.content_rows;
      end
   end

   ps2ws_step #(.ROW_BITS(ROW_BITS)) u_step (
      .cfg              (cfg_ff),
      .item             (s1_item_ff),
      .pos              (pos_ff),
      .scroll_time      (scroll_time_ff),
      .view             (view_ff),
      .pos_next         (pos_in),
      .scroll_time_next (scroll_time_in),
      .view_next        (view_in),
      .result           (result_in)
   );

   // framer state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= POS_SYNC;
         scroll_time_ff <= '0;
         view_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (s1_fire) begin
            pos_ff         <= pos_in;
            scroll_time_ff <= scroll_time_in;
            view_ff        <= view_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (s1_fire) rsp_ff <= result_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.view_row    = rsp_ff.view_row;
   assign rsp_chan.refresh     = rsp_ff.refresh;
   assign rsp_chan.packet_done = rsp_ff.packet_done;
   assign rsp_chan.sync_drop   = rsp_ff.sync_drop;

   a_drop_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.sync_drop && rsp_ff.packet_done))
      else $error("sync drop and packet done on the same word");

   a_refresh_on_wheel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.refresh) |-> rsp_ff.packet_done)
      else $error("refresh on a word that did not end a packet");

   a_wrap_after_wheel: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && pos_ff == POS_WHEEL) |=> pos_ff == POS_SYNC)
      else $error("framer did not return to sync after wheel byte");

   a_view_holds_idle: assert property (@(posedge clock) disable iff (reset)
      !s1_fire |=> $stable(view_ff) && $stable(scroll_time_ff))
      else $error("scroll state changed without a byte");

endmodule

// ----- hw/rtl/ps2ws_step.sv -----
// one-word packet framing and wheel scroll update, pure combinational
// depends on ps2ws_pkg
module ps2ws_step #(
   parameter int ROW_BITS = ps2ws_pkg::ROW_BITS_DEF
) (
   input  ps2ws_pkg::cfg_type                cfg,
   input  ps2ws_pkg::item_type               item,
   input  ps2ws_pkg::pos_type                pos,
   input  logic [ps2ws_pkg::TIME_W-1:0]      scroll_time,
   input  logic [ROW_BITS-1:0]               view,
   output ps2ws_pkg::pos_type                pos_next,
   output logic [ps2ws_pkg::TIME_W-1:0]      scroll_time_next,
   output logic [ROW_BITS-1:0]               view_next,
   output ps2ws_pkg::result_type             result
);
   import ps2ws_pkg::*;

   localparam int SUM_W = ((ROW_BITS > FIELD_W) ? ROW_BITS : FIELD_W) + 2;
   localparam logic [SUM_W-1:0] ROW_MAX = SUM_W'((33'd1 << ROW_BITS) - 33'd1);

   logic [TIME_W-1:0] gap;
   logic [MULT_W-1:0] step;
   logic [SUM_W-1:0]  old_w, step_w, scr_w, head_w;
   logic [SUM_W-1:0]  room, adv, down_sum, down_row, up_row;
   logic              blocked, wheel_move;
   logic [SUM_W-1:0]  new_w;

   assign gap    = item.time_stamp - scroll_time;
   assign step   = (gap < cfg.fast_threshold) ? cfg.fast_multiplier : SLOW_STEP;
   assign old_w  = SUM_W'(view);
   assign step_w = SUM_W'(step);
   assign scr_w  = SUM_W'(cfg.screen_rows);
   assign head_w = SUM_W'(item.content_rows);

   // down: advance while view + screen rows stays within the content
   assign blocked  = (old_w + scr_w) > head_w;
   assign room     = head_w + SUM_W'(1) - scr_w - old_w;
   assign adv      = (step_w < room) ? step_w : room;
   assign down_sum = old_w + adv;
   assign down_row = blocked ? old_w : ((down_sum > ROW_MAX) ? ROW_MAX : down_sum);
   assign up_row   = (old_w >= step_w) ? (old_w - step_w) : '0;

   assign wheel_move = (pos == POS_WHEEL) && (item.data_byte != '0);
   assign new_w = item.data_byte[SIGN_BIT] ? up_row : down_row;

   assign scroll_time_next = wheel_move ? item.time_stamp : scroll_time;
   assign view_next        = wheel_move ? new_w[ROW_BITS-1:0] : view;

   always_comb begin
      pos_next = pos;
      result.sync_drop   = 1'b0;
      result.packet_done = 1'b0;
      result.refresh     = (view_next != view);
      result.view_row    = FIELD_W'(SUM_W'(view_next));
      case (pos)
         POS_SYNC: begin
            if (item.data_byte[SYNC_BIT]) pos_next = POS_X;
            else result.sync_drop = 1'b1;
         end
         POS_X:     pos_next = POS_Y;
         POS_Y:     pos_next = POS_WHEEL;
         POS_WHEEL: begin
            pos_next = POS_SYNC;
            result.packet_done = 1'b1;
         end
         default:   pos_next = POS_SYNC;
      endcase
   end

endmodule

// ----- sim/ps2ws_checker.sv -----
// result checker for the ps2 wheel scroll core: mirrors the registers, predicts each result word
// from the accepted input words and compares it with what the core hands out
// depends on ps2ws_pkg and ps2ws_if
module ps2ws_checker (
   input  logic                            clock,
   input  logic                            reset,
   ps2ws_req_if                            req_mon,
   ps2ws_rsp_if                            rsp_mon,
   input  logic                            csr_we,
   input  logic [ps2ws_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ps2ws_pkg::TIME_W-1:0]    csr_wdata,
   output int                              fail_count,
   output int                              pending_count,
   output int                              words_checked,
   output int                              view_changes
);
   import ps2ws_pkg::*;

   localparam int ROW_LIMIT = (1 << ROW_BITS_DEF) - 1;
   localparam int REPORT_MAX = 10;

   cfg_type           regs;
   pos_type           frame_pos;
   logic [TIME_W-1:0] last_wheel_time;
   int                view;
   result_type        expected_views[$];

   // one framing and scroll step, updates the mirrored state
   function automatic result_type frame_and_scroll(item_type word);
      result_type        res;
      int                old_row, row, step, room, head, rows;
      logic [TIME_W-1:0] gap;
      res = '0;
      old_row = view;
      row = old_row;
      case (frame_pos)
         POS_SYNC: begin
            if (word.data_byte[SYNC_BIT]) frame_pos = POS_X;
            else res.sync_drop = 1'b1;
         end
         POS_X: frame_pos = POS_Y;
         POS_Y: frame_pos = POS_WHEEL;
         default: begin
            frame_pos = POS_SYNC;
            res.packet_done = 1'b1;
            if (word.data_byte != '0) begin
               gap = word.time_stamp - last_wheel_time;
               last_wheel_time = word.time_stamp;
               step = (gap < regs.fast_threshold) ? int'(regs.fast_multiplier)
                                                  : int'(SLOW_STEP);
               if (word.data_byte[SIGN_BIT]) begin
                  row = (old_row >= step) ? old_row - step : 0;
               end else begin
                  head = int'(word.content_rows);
                  rows = int'(regs.screen_rows);
                  // advance only while the last visible row stays within the content
                  if (old_row + rows <= head) begin
                     room = head - rows - old_row + 1;
                     row = old_row + ((step < room) ? step : room);
                     if (row > ROW_LIMIT) row = ROW_LIMIT;
                  end
               end
            end
         end
      endcase
      view = row;
      res.view_row = FIELD_W'(row);
      res.refresh = (row != old_row);
      return res;
   endfunction

   always @(posedge clock) begin : watch
      item_type   word;
      result_type got, want;
      if (reset) begin
         regs.fast_threshold = FAST_THRESHOLD_RST;
         regs.fast_multiplier = FAST_MULTIPLIER_RST;
         regs.screen_rows = SCREEN_ROWS_RST;
         frame_pos = POS_SYNC;
         last_wheel_time = '0;
         view = 0;
         expected_views.delete();
         fail_count = 0;
         pending_count = 0;
         words_checked = 0;
         view_changes = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_FAST_THRESHOLD:  regs.fast_threshold = csr_wdata;
               CSR_FAST_MULTIPLIER: regs.fast_multiplier = csr_wdata[MULT_W-1:0];
               CSR_SCREEN_ROWS:     regs.screen_rows = csr_wdata[FIELD_W-1:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.view_row = rsp_mon.view_row;
            got.refresh = rsp_mon.refresh;
            got.packet_done = rsp_mon.packet_done;
            got.sync_drop = rsp_mon.sync_drop;
            if (expected_views.size() == 0) begin
               if (fail_count < REPORT_MAX)
                  $display("unexpected result word: row %0d refresh %0b done %0b drop %0b",
                           got.view_row, got.refresh, got.packet_done, got.sync_drop);
               fail_count++;
            end else begin
               want = expected_views.pop_front();
               if (got !== want) begin
                  if (fail_count < REPORT_MAX)
                     $display({"word %0d mismatch: expected row %0d refresh %0b done %0b ",
                               "drop %0b, got row %0d refresh %0b done %0b drop %0b"},
                              words_checked, want.view_row, want.refresh, want.packet_done,
                              want.sync_drop, got.view_row, got.refresh, got.packet_done,
                              got.sync_drop);
                  fail_count++;
               end
               if (want.refresh) view_changes++;
               words_checked++;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            word.data_byte = req_mon.data_byte;
            word.time_stamp = req_mon.time_stamp;
            word.content_rows = req_mon.content_rows;
            expected_views.push_back(frame_and_scroll(word));
         end
         pending_count = expected_views.size();
      end
   end

endmodule

// ----- sim/testbench.sv -----
// top of the ps2 wheel scroll simulation: clock, reset, register setups and mouse byte traffic
// with random gaps and stalls on both channels; the verdict comes from ps2ws_checker
// depends on ps2ws_pkg, ps2ws_if, ps2_wheel_packet_scroll_core and ps2ws_checker
module testbench;
   import ps2ws_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 300;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;
   localparam logic [FIELD_W-1:0] HEAD_MAX = '1;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [TIME_W-1:0]    csr_wdata;

   int fail_count, pending_count, words_checked, view_changes;
   int bytes_sent = 0;
   int steady_bytes = 0;
   int content_level = 0;
   int cycle_count = 0;
   bit hold_request = 1'b0;
   logic [TIME_W-1:0] stamp_now = '0;
   logic [TIME_W-1:0] last_wheel_stamp = '0;
   logic [TIME_W-1:0] cur_thr = FAST_THRESHOLD_RST;

   ps2ws_req_if req_chan();
   ps2ws_rsp_if rsp_chan();

   ps2_wheel_packet_scroll_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ps2ws_checker view_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .words_checked (words_checked),
      .view_changes  (view_changes)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // mostly no gap, sometimes a few cycles, rarely a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [TIME_W-1:0] advance_stamp();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) stamp_now += TIME_W'($urandom_range(0, 2000000));
      else if (r < 80) stamp_now += TIME_W'($urandom_range(0, 40000000));
      else if (r >= 90) stamp_now += {$urandom, $urandom};
      return stamp_now;
   endfunction

   // content grows slowly so downward scrolls keep meeting the limit
   function automatic logic [FIELD_W-1:0] pick_head();
      int r;
      r = $urandom_range(0, 99);
      content_level = (content_level + $urandom_range(0, 2)) % 4096;
      if (r < 70) return FIELD_W'(content_level);
      if (r < 80) return FIELD_W'((content_level > 30) ? content_level - $urandom_range(0, 30)
                                                      : 0);
      if (r < 85) return '0;
      if (r < 90) return HEAD_MAX;
      return FIELD_W'($urandom);
   endfunction

   task automatic push_byte(input logic [BYTE_W-1:0] data, input logic [TIME_W-1:0] ts,
                            input logic [FIELD_W-1:0] head);
      int gap;
      req_chan.valid <= 1'b1;
      req_chan.data_byte <= data;
      req_chan.time_stamp <= ts;
      req_chan.content_rows <= head;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
      if (steady_bytes > 0) begin
         steady_bytes--;
      end else begin
         gap = gap_len();
         if ($urandom_range(0, 99) < 2) steady_bytes = $urandom_range(30, 100);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   task automatic send_packet(input logic [BYTE_W-1:0] b0, b1, b2, wheel,
                              input logic [TIME_W-1:0] ts, input logic [FIELD_W-1:0] head);
      push_byte(b0, ts, head);
      push_byte(b1, ts, head);
      push_byte(b2, ts, head);
      push_byte(wheel, ts, head);
   endtask

   // a few stray bytes, then four bytes without the sync bit bring the framer back to start
   task automatic send_noise();
      repeat ($urandom_range(1, 3)) push_byte(BYTE_W'($urandom), advance_stamp(),
                                              FIELD_W'($urandom));
      repeat (4) push_byte(BYTE_W'($urandom) & ~BYTE_W'(1 << SYNC_BIT), advance_stamp(),
                           FIELD_W'($urandom));
   endtask

   task automatic run_traffic(input int packets, down_pct, zero_pct, noise_pct, fixed_head);
      logic [BYTE_W-1:0]  wheel;
      logic [TIME_W-1:0]  ts;
      logic [FIELD_W-1:0] head;
      int r;
      repeat (packets) begin
         if ($urandom_range(0, 99) < noise_pct) send_noise();
         r = $urandom_range(0, 99);
         if (r < zero_pct) wheel = '0;
         else if ($urandom_range(0, 99) < down_pct)
            wheel = (r % 4 == 0) ? 8'h7F : (r % 4 == 1) ? 8'h01
                                         : BYTE_W'($urandom_range(1, 127));
         else
            wheel = (r % 4 == 0) ? 8'h80 : (r % 4 == 1) ? 8'hFF
                                         : BYTE_W'($urandom_range(128, 255));
         // land on both sides of the acceleration threshold now and then
         r = $urandom_range(0, 99);
         if (r < 20) ts = last_wheel_stamp + cur_thr - 1;
         else if (r < 40) ts = last_wheel_stamp + cur_thr;
         else ts = advance_stamp();
         stamp_now = ts;
         if (wheel != '0) last_wheel_stamp = ts;
         head = (fixed_head >= 0) ? FIELD_W'(fixed_head) : pick_head();
         send_packet(BYTE_W'($urandom) | BYTE_W'(1 << SYNC_BIT), BYTE_W'($urandom),
                     BYTE_W'($urandom), wheel, ts, head);
      end
   endtask

   task automatic quiesce();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // upper bits of the narrow registers carry junk that the core must ignore
   task automatic set_registers(input logic [TIME_W-1:0] thr, input int mult, rows);
      logic [TIME_W-1:0] word;
      write_reg(CSR_FAST_THRESHOLD, thr);
      word = {$urandom, $urandom};
      word[MULT_W-1:0] = MULT_W'(mult);
      write_reg(CSR_FAST_MULTIPLIER, word);
      word = {$urandom, $urandom};
      word[FIELD_W-1:0] = FIELD_W'(rows);
      write_reg(CSR_SCREEN_ROWS, word);
      cur_thr = thr;
   endtask

   initial begin : rsp_side
      int hold_left, stall_left, steady_left;
      bit hold_taken;
      hold_left = 0;
      stall_left = 0;
      steady_left = 0;
      hold_taken = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (steady_left > 0) steady_left--;
            else if ($urandom_range(0, 99) < 3) steady_left = $urandom_range(40, 150);
            else if ($urandom_range(0, 99) < 30) stall_left = gap_len();
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("run stopped after %0d cycles with %0d words outstanding",
               cycle_count, pending_count);
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_FAST_THRESHOLD;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.data_byte = '0;
      req_chan.time_stamp = '0;
      req_chan.content_rows = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // bytes without sync bit at packet start
      push_byte(8'h00, '0, '0);
      push_byte(8'hF7, 64'd1, HEAD_MAX);
      // down one notch, fast since the gap from reset is tiny
      send_packet(8'h08, 8'h00, 8'h00, 8'h01, 64'd100, HEAD_MAX);
      // gap equal to the threshold gives a single-row step
      send_packet(8'hFF, 8'hFF, 8'hFF, 8'hFF, 64'd10000100, HEAD_MAX);
      // gap just under the threshold, accelerated up scroll clamps at row 0
      send_packet(8'h08, 8'hAA, 8'h55, 8'h80, 64'd20000099, HEAD_MAX);
      // no room below, row holds but the scroll time still moves
      send_packet(8'h0F, 8'h55, 8'hAA, 8'h7F, 64'hFFFF_FFFF_FFFF_FFF0, '0);
      // time wraps around: small gap, step clipped by the room left
      send_packet(8'hF8, 8'h00, 8'hFF, 8'h01, 64'd5, 12'd26);
      // zero wheel value
      send_packet(8'h08, 8'hFF, 8'h00, 8'h00, TIME_MAX, HEAD_MAX);
      stamp_now = 64'd5;
      last_wheel_stamp = 64'd5;

      // reset register values, with a long output hold-off in the middle
      run_traffic(30, 60, 15, 10, -1);
      steady_bytes = 400;
      hold_request = 1'b1;
      run_traffic(50, 60, 15, 10, -1);
      quiesce();

      set_registers('0, 15, 4095);
      run_traffic(25, 50, 15, 10, -1);
      quiesce();

      set_registers(64'd1000, 0, 0);
      run_traffic(30, 50, 15, 10, -1);
      quiesce();

      // long downward run with the largest step
      set_registers(TIME_MAX, 15, 0);
      run_traffic(100, 100, 0, 0, int'(HEAD_MAX));
      quiesce();

      write_reg(CSR_SPARE, {$urandom, $urandom});
      set_registers({$urandom, $urandom}, $urandom_range(1, 15), $urandom_range(1, 40));
      run_traffic(40, 25, 15, 10, -1);
      quiesce();

      set_registers(64'd20000000, 1, 1);
      run_traffic(25, 50, 15, 10, -1);
      quiesce();

      repeat (10) @(negedge clock);
      $display("%0d bytes sent, %0d result words checked, %0d of them moved the view",
               bytes_sent, words_checked, view_changes);
      $display("setups: reset values, zero/full/random threshold, step 0/1/15, rows 0/1/4095");
      if (fail_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
